// ----- rtl/core/stfr_pkg.sv -----
// Package for the scrolling text frame renderer.
// Holds the item kinds, the control states, character codes and small helper functions.
// Used by scrolling_text_frame_renderer_unit; depends on nothing else.
package stfr_pkg;

  localparam int TextCharsDefault = 80;
  localparam int PanelsDefault    = 8;
  localparam int GlyphPitch       = 9;
  localparam int NumGlyphs        = 27;
  localparam int OtherGlyph       = 26;
  localparam int LenW             = 7;
  localparam int OffsetW          = 10;
  localparam int LimitW           = 11;
  localparam int CntW             = 4;
  localparam int BootLen          = 12;

  localparam logic [7:0] CharLf     = 8'h0A;
  localparam logic [7:0] CharCr     = 8'h0D;
  localparam logic [7:0] CharUpperA = 8'h41;
  localparam logic [7:0] CharUpperZ = 8'h5A;
  localparam logic [7:0] CharLowerA = 8'h61;
  localparam logic [7:0] CharLowerZ = 8'h7A;
  localparam logic [7:0] CaseDelta  = 8'd32;
  localparam logic [7:0] CharSpace  = 8'h20;

  typedef enum logic [1:0] {
    KIND_TEXT = 2'd0,
    KIND_FONT = 2'd1,
    KIND_TICK = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    ST_IDLE   = 2'd0,
    ST_RENDER = 2'd1,
    ST_EMIT   = 2'd2
  } state_e;

  function automatic logic [7:0] to_upper(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c >= CharLowerA && c <= CharLowerZ) begin
      r = c - CaseDelta;
    end
    return r;
  endfunction

  function automatic logic [4:0] glyph_of(input logic [7:0] c);
    logic [7:0] d;
    logic [4:0] g;
    d = c - CharUpperA;
    g = 5'(OtherGlyph);
    if (c >= CharUpperA && c <= CharUpperZ) begin
      g = d[4:0];
    end
    return g;
  endfunction

  // Text shown after reset: "HELLO WORLD " then zeros.
  function automatic logic [7:0] boot_char(input logic [LenW-1:0] idx);
    logic [7:0] c;
    case (idx)
      7'd0:    c = 8'h48;
      7'd1:    c = 8'h45;
      7'd2:    c = 8'h4C;
      7'd3:    c = 8'h4C;
      7'd4:    c = 8'h4F;
      7'd5:    c = CharSpace;
      7'd6:    c = 8'h57;
      7'd7:    c = 8'h4F;
      7'd8:    c = 8'h52;
      7'd9:    c = 8'h4C;
      7'd10:   c = 8'h44;
      7'd11:   c = CharSpace;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] rev8(input logic [7:0] b);
    logic [7:0] r;
    for (int i = 0; i < 8; i++) begin
      r[i] = b[7-i];
    end
    return r;
  endfunction

endpackage

// ----- rtl/core/scrolling_text_frame_renderer_unit.sv -----
// Top level of the scrolling text frame renderer: text line buffers, font memory,
// frame assembly and row output register.
// Depends on stfr_pkg.
//
// Channel   Dir  Word contents
// s_axis    in   tuser: kind; tdata: char_byte, glyph_index, glyph_row, glyph_bits
// m_axis    out  tdata: row_index, row_pixels; tlast: last_row
//
// Text bytes and font writes are accepted only while idle. After its accepting cycle a scroll
// tick assembles the frame (one text read and one font read per visible character, through
// the two memory read stages), then emits one row per cycle while the output is taken. Reset
// needs no clearing pass; the startup text comes from a constant until the first line end. A
// stalled output holds its row and blocks the next one.
module scrolling_text_frame_renderer_unit #(
  parameter int TEXT_CHARS = stfr_pkg::TextCharsDefault,
  parameter int PANELS     = stfr_pkg::PanelsDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // [7:0] char_byte, [12:8] glyph_index, [15:13] glyph_row, [23:16] glyph_bits
  input  logic [23:0] s_axis_tdata_i,
  // [1:0] kind
  input  logic [1:0]  s_axis_tuser_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // [2:0] row_index, [66:3] row_pixels, [71:67] zero
  output logic [71:0] m_axis_tdata_o,
  output logic        m_axis_tlast_o
);

  localparam int ScreenCols = 8 * PANELS;
  localparam int NumSlots   = (ScreenCols + 16) / stfr_pkg::GlyphPitch;
  localparam int SlotW      = stfr_pkg::GlyphPitch * NumSlots;
  localparam int WideW      = SlotW + ScreenCols;
  localparam int AddrW      = $clog2(TEXT_CHARS);
  localparam int MemDepth   = 2 ** (AddrW + 1);
  localparam int LenW       = stfr_pkg::LenW;
  localparam int OffsetW    = stfr_pkg::OffsetW;
  localparam int LimitW     = stfr_pkg::LimitW;
  localparam int CntW       = stfr_pkg::CntW;

  stfr_pkg::state_e state_q, state_d;

  logic                accept;
  logic                tready;
  logic                issue_en;
  logic                emit_load;
  logic [7:0]          char_byte;
  logic [4:0]          glyph_index;
  logic [2:0]          glyph_row;
  logic [7:0]          glyph_bits;
  logic [7:0]          char_up;

  logic                text_bank_q, text_bank_d;
  logic                boot_q, boot_d;
  logic [LenW-1:0]     text_len_q, text_len_d;
  logic [LenW-1:0]     line_cnt_q, line_cnt_d;
  logic [OffsetW-1:0]  offset_q, offset_d;
  logic [LenW-1:0]     ph_idx_q, ph_idx_d;
  logic [3:0]          ph_bit_q, ph_bit_d;
  logic [LimitW-1:0]   limit;
  logic [LimitW-1:0]   next_off;

  logic                line_we;
  logic                font_we;

  logic [6:0]          shamt_q, shamt_d;
  logic                right_q, right_d;
  logic [LenW-1:0]     base_idx_q, base_idx_d;
  logic [CntW-1:0]     cnt_q, cnt_d;
  logic [LenW-1:0]     issue_idx;

  logic [7:0]          text_mem [MemDepth];
  logic [7:0]          text_rd_q;
  logic [AddrW:0]      text_raddr;
  logic [AddrW:0]      text_waddr;
  logic [63:0]         font_mem [stfr_pkg::NumGlyphs];
  logic [63:0]         font_rd_q;
  logic [4:0]          glyph_sel;
  logic [7:0]          char_s1;

  logic                s1_live_q, s1_vld_q, s2_live_q, s2_vld_q;
  logic [LenW-1:0]     s1_idx_q;
  logic [SlotW-1:0]    concat_q [8];

  logic [2:0]          row_q, row_d;
  logic                m_valid_q, m_valid_d;
  logic [2:0]          m_row_q;
  logic [63:0]         m_pix_q;
  logic                m_last_q;
  logic [WideW-1:0]    wide_row;
  logic [SlotW-1:0]    right_row;
  logic [ScreenCols-1:0] row_pix;

  assign char_byte   = s_axis_tdata_i[7:0];
  assign glyph_index = s_axis_tdata_i[12:8];
  assign glyph_row   = s_axis_tdata_i[15:13];
  assign glyph_bits  = s_axis_tdata_i[23:16];
  assign char_up     = stfr_pkg::to_upper(char_byte);
  assign accept      = s_axis_tvalid_i & tready;

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      stfr_pkg::ST_IDLE: begin
        if (accept && s_axis_tuser_i == stfr_pkg::KIND_TICK) begin
          state_d = stfr_pkg::ST_RENDER;
        end
      end
      stfr_pkg::ST_RENDER: begin
        if (cnt_q == CntW'(NumSlots + 1)) begin
          state_d = stfr_pkg::ST_EMIT;
        end
      end
      stfr_pkg::ST_EMIT: begin
        if (emit_load && row_q == 3'd7) begin
          state_d = stfr_pkg::ST_IDLE;
        end
      end
      default: state_d = stfr_pkg::ST_IDLE;
    endcase
  end

  // State outputs.
  always_comb begin
    tready    = 1'b0;
    issue_en  = 1'b0;
    emit_load = 1'b0;
    case (state_q)
      stfr_pkg::ST_IDLE: begin
        tready = 1'b1;
      end
      stfr_pkg::ST_RENDER: begin
        issue_en = (cnt_q < CntW'(NumSlots));
      end
      stfr_pkg::ST_EMIT: begin
        emit_load = !m_valid_q || m_axis_tready_i;
      end
      default: begin
        tready = 1'b0;
      end
    endcase
  end

  assign limit    = LimitW'({text_len_q, 3'b000}) + LimitW'(text_len_q) + LimitW'(ScreenCols);
  assign next_off = LimitW'(offset_q) + LimitW'(1);

  // Text line, scroll position and render setup.
  always_comb begin
    text_bank_d = text_bank_q;
    boot_d      = boot_q;
    text_len_d  = text_len_q;
    line_cnt_d  = line_cnt_q;
    offset_d    = offset_q;
    ph_idx_d    = ph_idx_q;
    ph_bit_d    = ph_bit_q;
    right_d     = right_q;
    shamt_d     = shamt_q;
    base_idx_d  = base_idx_q;
    line_we     = 1'b0;
    font_we     = 1'b0;
    if (accept) begin
      case (s_axis_tuser_i)
        stfr_pkg::KIND_TEXT: begin
          if (char_byte == stfr_pkg::CharLf || char_byte == stfr_pkg::CharCr) begin
            if (line_cnt_q != '0) begin
              text_bank_d = ~text_bank_q;
              boot_d      = 1'b0;
              text_len_d  = line_cnt_q;
              line_cnt_d  = '0;
              offset_d    = '0;
              ph_idx_d    = '0;
              ph_bit_d    = '0;
            end
          end else if (line_cnt_q < LenW'(TEXT_CHARS - 1)) begin
            line_we    = 1'b1;
            line_cnt_d = line_cnt_q + LenW'(1);
          end
        end
        stfr_pkg::KIND_FONT: begin
          font_we = (glyph_index < 5'(stfr_pkg::NumGlyphs));
        end
        stfr_pkg::KIND_TICK: begin
          right_d    = (offset_q >= OffsetW'(ScreenCols));
          shamt_d    = right_d ? {3'b000, ph_bit_q}
                               : 7'(LimitW'(ScreenCols) - LimitW'(offset_q));
          base_idx_d = right_d ? ph_idx_q : '0;
          if (next_off > limit || next_off[LimitW-1]) begin
            offset_d = '0;
            ph_idx_d = '0;
            ph_bit_d = '0;
          end else begin
            offset_d = next_off[OffsetW-1:0];
            if (next_off > LimitW'(ScreenCols)) begin
              if (ph_bit_q == 4'(stfr_pkg::GlyphPitch - 1)) begin
                ph_bit_d = '0;
                ph_idx_d = ph_idx_q + LenW'(1);
              end else begin
                ph_bit_d = ph_bit_q + 4'd1;
              end
            end
          end
        end
        default: begin
          line_we = 1'b0;
        end
      endcase
    end
  end

  assign cnt_d     = (state_q == stfr_pkg::ST_RENDER) ? cnt_q + CntW'(1) : '0;
  assign issue_idx = base_idx_q + LenW'(cnt_q);
  assign row_d     = (state_q != stfr_pkg::ST_EMIT) ? 3'd0 :
                     (emit_load ? row_q + 3'd1 : row_q);
  assign m_valid_d = emit_load ? 1'b1 : (m_axis_tready_i ? 1'b0 : m_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= stfr_pkg::ST_IDLE;
      text_bank_q <= 1'b0;
      boot_q      <= 1'b1;
      text_len_q  <= LenW'(stfr_pkg::BootLen);
      line_cnt_q  <= '0;
      offset_q    <= '0;
      ph_idx_q    <= '0;
      ph_bit_q    <= '0;
      cnt_q       <= '0;
      row_q       <= '0;
      m_valid_q   <= 1'b0;
      s1_live_q   <= 1'b0;
      s2_live_q   <= 1'b0;
    end else begin
      state_q     <= state_d;
      text_bank_q <= text_bank_d;
      boot_q      <= boot_d;
      text_len_q  <= text_len_d;
      line_cnt_q  <= line_cnt_d;
      offset_q    <= offset_d;
      ph_idx_q    <= ph_idx_d;
      ph_bit_q    <= ph_bit_d;
      cnt_q       <= cnt_d;
      row_q       <= row_d;
      m_valid_q   <= m_valid_d;
      s1_live_q   <= issue_en;
      s2_live_q   <= s1_live_q;
    end
  end

  always_ff @(posedge clk_i) begin
    right_q    <= right_d;
    shamt_q    <= shamt_d;
    base_idx_q <= base_idx_d;
    s1_vld_q   <= issue_idx < text_len_q;
    s1_idx_q   <= issue_idx;
    s2_vld_q   <= s1_vld_q;
  end

  // Two line buffers: one holds the shown text, the other collects the next line.
  assign text_raddr = {text_bank_q, issue_idx[AddrW-1:0]};
  assign text_waddr = {~text_bank_q, line_cnt_q[AddrW-1:0]};

  always_ff @(posedge clk_i) begin
    if (line_we) begin
      text_mem[text_waddr] <= char_up;
    end
    text_rd_q <= text_mem[text_raddr];
  end

  assign char_s1   = boot_q ? stfr_pkg::boot_char(s1_idx_q) : text_rd_q;
  assign glyph_sel = stfr_pkg::glyph_of(char_s1);

  // Each font entry holds all eight rows of one glyph, row r in byte r.
  always_ff @(posedge clk_i) begin
    if (font_we) begin
      font_mem[glyph_index][glyph_row*8 +: 8] <= glyph_bits;
    end
    font_rd_q <= font_mem[glyph_sel];
  end

  // Slots enter from the top, so the first visible character ends up in the lowest bits.
  always_ff @(posedge clk_i) begin
    if (s2_live_q) begin
      for (int r = 0; r < 8; r++) begin
        concat_q[r] <= {(s2_vld_q ? {1'b0, stfr_pkg::rev8(font_rd_q[r*8 +: 8])} : 9'd0),
                        concat_q[r][SlotW-1:stfr_pkg::GlyphPitch]};
      end
    end
  end

  assign wide_row  = {{ScreenCols{1'b0}}, concat_q[row_q]} << shamt_q;
  assign right_row = concat_q[row_q] >> shamt_q;
  assign row_pix   = right_q ? right_row[ScreenCols-1:0] : wide_row[ScreenCols-1:0];

  always_ff @(posedge clk_i) begin
    if (emit_load) begin
      m_row_q  <= row_q;
      m_pix_q  <= 64'(row_pix);
      m_last_q <= (row_q == 3'd7);
    end
  end

  assign s_axis_tready_o = tready;
  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = {5'b00000, m_pix_q, m_row_q};
  assign m_axis_tlast_o  = m_last_q;

`ifndef ASSERT_OFF
  a_offset_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    LimitW'(offset_q) <= limit)
    else $error("scroll offset beyond wrap limit");

  a_phase_zero_on_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (offset_q < OffsetW'(ScreenCols)) |-> (ph_idx_q == '0 && ph_bit_q == '0))
    else $error("scroll phase not cleared while text is entering");

  a_phase_bit_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ph_bit_q < 4'(stfr_pkg::GlyphPitch) && line_cnt_q < LenW'(TEXT_CHARS))
    else $error("phase column or line count out of range");

  a_slot_shift_in_render: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s2_live_q |-> state_q == stfr_pkg::ST_RENDER)
    else $error("frame slot shifted outside rendering");

  a_emit_after_render: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == stfr_pkg::ST_RENDER && state_d == stfr_pkg::ST_EMIT) |-> !s1_live_q)
    else $error("rendering finished with a character still in flight");
`endif

endmodule
